// ===== src/anlp_pkg.sv =====
package anlp_pkg;

   typedef enum logic [2:0] {
      PH_START,
      PH_STAMP,
      PH_SKIP_A,
      PH_HDR,
      PH_SKIP_B,
      PH_PGN,
      PH_DATA,
      PH_WAIT
   } phase_type;

   localparam logic       KIND_DATA    = 1'b0;
   localparam logic       KIND_SUMMARY = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_TYPE  = 2'd1;
   localparam logic [1:0] STATUS_EARLY_END = 2'd2;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_A     = 8'h41;

   // header: two source digits, two destination digits, one priority digit
   localparam logic [2:0] SRC_DIGITS   = 3'd2;
   localparam logic [2:0] ADDR_DIGITS  = 3'd4;
   localparam logic [2:0] FIELD_DIGITS = 3'd5;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [7:0]  source_addr;
      logic [7:0]  dest_addr;
      logic [3:0]  prio;
      logic [19:0] pgn_value;
      logic [7:0]  payload_len;
      logic [1:0]  status;
   } result_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
      else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
      else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
      return v[3:0];
   endfunction

endpackage

// ===== src/anlp_core.sv =====
module anlp_core import anlp_pkg::*; #(
   parameter int MAX_PAYLOAD = 223
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] char_code,
   output logic       res_valid,
   output result_type res
);

   localparam logic [7:0] MAX_CNT = 8'(MAX_PAYLOAD);

   phase_type   phase_ff, phase_in;
   logic [2:0]  fc_ff, fc_in;
   logic [7:0]  src_ff, src_in;
   logic [7:0]  dst_ff, dst_in;
   logic [3:0]  prio_ff, prio_in;
   logic [19:0] pgn_ff, pgn_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic        pend_v_ff, pend_v_in;
   logic [3:0]  pend_nib_ff, pend_nib_in;
   logic        fail_ff, fail_in;

   logic       clr;
   logic       to_wait;
   logic [3:0] nib;
   logic [2:0] fc_eff;
   logic [2:0] fc_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         fc_ff       <= '0;
         src_ff      <= '0;
         dst_ff      <= '0;
         prio_ff     <= '0;
         pgn_ff      <= '0;
         cnt_ff      <= '0;
         pend_v_ff   <= 1'b0;
         pend_nib_ff <= '0;
         fail_ff     <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         fc_ff       <= fc_in;
         src_ff      <= src_in;
         dst_ff      <= dst_in;
         prio_ff     <= prio_in;
         pgn_ff      <= pgn_in;
         cnt_ff      <= cnt_in;
         pend_v_ff   <= pend_v_in;
         pend_nib_ff <= pend_nib_in;
         fail_ff     <= fail_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      fc_in       = fc_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      prio_in     = prio_ff;
      pgn_in      = pgn_ff;
      cnt_in      = cnt_ff;
      pend_v_in   = pend_v_ff;
      pend_nib_in = pend_nib_ff;
      fail_in     = fail_ff;
      clr         = 1'b0;
      to_wait     = 1'b0;
      res_valid   = 1'b0;
      res         = '0;
      nib         = nibble_of(char_code);
      // the first digit of a field is the character that ends the space run
      fc_eff      = (phase_ff == PH_SKIP_A || phase_ff == PH_SKIP_B) ? 3'd0 : fc_ff;
      fc_next     = fc_eff + 3'd1;

      if (step) begin
         unique case (phase_ff)
            PH_START: begin
               if (char_code == CHAR_A) begin
                  phase_in = PH_STAMP;
               end else if (char_code == CHAR_NUL) begin
                  res_valid      = 1'b1;
                  res.item_kind  = KIND_SUMMARY;
                  res.status     = STATUS_BAD_TYPE;
                  clr            = 1'b1;
               end else begin
                  fail_in  = 1'b1;
                  phase_in = PH_WAIT;
               end
            end
            PH_STAMP: begin
               if (char_code == CHAR_NUL) begin
                  res_valid     = 1'b1;
                  res.item_kind = KIND_SUMMARY;
                  res.status    = STATUS_EARLY_END;
                  clr           = 1'b1;
               end else if (char_code == CHAR_SPACE) begin
                  phase_in = PH_SKIP_A;
               end
            end
            PH_SKIP_A, PH_HDR: begin
               if (char_code == CHAR_NUL) begin
                  res_valid     = 1'b1;
                  res.item_kind = KIND_SUMMARY;
                  res.status    = STATUS_EARLY_END;
                  clr           = 1'b1;
               end else if (!(phase_ff == PH_SKIP_A && char_code == CHAR_SPACE)) begin
                  if (fc_eff < SRC_DIGITS) src_in = {src_ff[3:0], nib};
                  else if (fc_eff < ADDR_DIGITS) dst_in = {dst_ff[3:0], nib};
                  else prio_in = nib;
                  if (fc_next >= FIELD_DIGITS) begin
                     fc_in    = '0;
                     phase_in = PH_SKIP_B;
                  end else begin
                     fc_in    = fc_next;
                     phase_in = PH_HDR;
                  end
               end
            end
            PH_SKIP_B, PH_PGN: begin
               if (char_code == CHAR_NUL) begin
                  res_valid     = 1'b1;
                  res.item_kind = KIND_SUMMARY;
                  res.status    = STATUS_EARLY_END;
                  clr           = 1'b1;
               end else if (!(phase_ff == PH_SKIP_B && char_code == CHAR_SPACE)) begin
                  pgn_in = {pgn_ff[15:0], nib};
                  if (fc_next >= FIELD_DIGITS) begin
                     fc_in     = '0;
                     phase_in  = PH_DATA;
                     pend_v_in = 1'b0;
                  end else begin
                     fc_in    = fc_next;
                     phase_in = PH_PGN;
                  end
               end
            end
            PH_DATA: begin
               if (char_code == CHAR_NUL || char_code == CHAR_CR || char_code == CHAR_LF) begin
                  res_valid       = 1'b1;
                  res.item_kind   = KIND_SUMMARY;
                  res.status      = STATUS_OK;
                  res.source_addr = src_ff;
                  res.dest_addr   = dst_ff;
                  res.prio        = prio_ff;
                  res.pgn_value   = pgn_ff;
                  res.payload_len = cnt_ff;
                  clr             = 1'b1;
                  to_wait         = (char_code != CHAR_NUL);
               end else if (!is_hex(char_code)) begin
                  pend_v_in = 1'b0;
               end else if (!pend_v_ff) begin
                  pend_v_in   = 1'b1;
                  pend_nib_in = nib;
               end else begin
                  pend_v_in = 1'b0;
                  if (cnt_ff < MAX_CNT) begin
                     res_valid      = 1'b1;
                     res.item_kind  = KIND_DATA;
                     res.data_byte  = {pend_nib_ff, nib};
                     res.byte_index = cnt_ff;
                     cnt_in         = cnt_ff + 8'd1;
                  end
               end
            end
            PH_WAIT: begin
               if (char_code == CHAR_NUL) begin
                  if (fail_ff) begin
                     res_valid     = 1'b1;
                     res.item_kind = KIND_SUMMARY;
                     res.status    = STATUS_BAD_TYPE;
                  end
                  clr = 1'b1;
               end
            end
            default: phase_in = PH_START;
         endcase
      end

      if (clr) begin
         phase_in    = to_wait ? PH_WAIT : PH_START;
         fc_in       = '0;
         src_in      = '0;
         dst_in      = '0;
         prio_in     = '0;
         pgn_in      = '0;
         cnt_in      = '0;
         pend_v_in   = 1'b0;
         pend_nib_in = '0;
         fail_in     = 1'b0;
      end
   end

endmodule

// ===== src/ascii_n2k_line_parser_unit.sv =====
// Text line parser for lines of the form A<timestamp> SSDDP PPPPP <hex pairs>, fed one
// character per transfer and ended by NUL. Each stored data byte leaves as one result with
// its index; CR, LF or NUL in the data phase, NUL in an earlier phase, or NUL after
// a failed line gives one summary result. Throughput is one character per cycle while
// the result side does not stall: a character sits in the input register, and decode
// logic updates the line state and loads the result register once the result slot is
// free or being drained. While a result waits, one more character can be taken into an
// empty input register; after that req_ready follows rsp_ready.
module ascii_n2k_line_parser_unit import anlp_pkg::*; #(
   parameter int MAX_PAYLOAD = 223
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_item_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_byte_index,
   output logic [7:0]  rsp_source_addr,
   output logic [7:0]  rsp_dest_addr,
   output logic [3:0]  rsp_prio,
   output logic [19:0] rsp_pgn_value,
   output logic [7:0]  rsp_payload_len,
   output logic [1:0]  rsp_status
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       advance;
   logic       res_valid;
   result_type res;

   // a character is decoded once the result slot is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   anlp_core #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_code (in_char_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_char_in   = in_char_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_char_in  = req_char_code;
      end
      if (rsp_ready) out_valid_in = 1'b0;
      if (advance && res_valid) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      out_ff     <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_item_kind   = out_ff.item_kind;
   assign rsp_data_byte   = out_ff.data_byte;
   assign rsp_byte_index  = out_ff.byte_index;
   assign rsp_source_addr = out_ff.source_addr;
   assign rsp_dest_addr   = out_ff.dest_addr;
   assign rsp_prio        = out_ff.prio;
   assign rsp_pgn_value   = out_ff.pgn_value;
   assign rsp_payload_len = out_ff.payload_len;
   assign rsp_status      = out_ff.status;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import anlp_pkg::*;

   localparam int LINE_BYTES_MAX = 223;
   localparam int ITEM_TARGET    = 1450;
   localparam int QUIET_LIMIT    = 1000;
   localparam int DRAIN_CYCLES   = 8;

   localparam result_type NO_RESULT = '0;

   typedef struct {
      logic [7:0] ch;
      bit         typed;
      result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_item_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_byte_index;
   logic [7:0]  rsp_source_addr;
   logic [7:0]  rsp_dest_addr;
   logic [3:0]  rsp_prio;
   logic [19:0] rsp_pgn_value;
   logic [7:0]  rsp_payload_len;
   logic [1:0]  rsp_status;

   ascii_n2k_line_parser_unit #(.MAX_PAYLOAD(LINE_BYTES_MAX)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_code(req_char_code),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item_kind(rsp_item_kind),
      .rsp_data_byte(rsp_data_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_source_addr(rsp_source_addr),
      .rsp_dest_addr(rsp_dest_addr),
      .rsp_prio(rsp_prio),
      .rsp_pgn_value(rsp_pgn_value),
      .rsp_payload_len(rsp_payload_len),
      .rsp_status(rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // line state of the parser as the testbench sees it
   phase_type   line_phase = PH_START;
   logic [2:0]  digit_cnt = '0;
   logic [7:0]  hdr_src = '0;
   logic [7:0]  hdr_dst = '0;
   logic [3:0]  hdr_prio = '0;
   logic [19:0] hdr_pgn = '0;
   logic [7:0]  stored_bytes = '0;
   logic        half_valid = 1'b0;
   logic [3:0]  half_nib = '0;
   logic        bad_type = 1'b0;

   result_type  parsed_items[$];
   int          mismatches = 0;
   int          live_chars = 0;
   int          quiet = 0;
   bit          req_burst = 1'b0;
   bit          rsp_burst = 1'b0;

   // bit 4 flags a hex digit, bits 3..0 hold its value (0 for anything else)
   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return {1'b1, ch[3:0]};
      if ((ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f"))
         return {1'b1, ch[3:0] + 4'd9};
      return 5'd0;
   endfunction

   function automatic result_type close_line(input logic [1:0] st);
      result_type res;
      res = '0;
      res.item_kind = KIND_SUMMARY;
      res.status = st;
      if (st == STATUS_OK) begin
         res.source_addr = hdr_src;
         res.dest_addr = hdr_dst;
         res.prio = hdr_prio;
         res.pgn_value = hdr_pgn;
         res.payload_len = stored_bytes;
      end
      line_phase = PH_START;
      digit_cnt = '0;
      hdr_src = '0;
      hdr_dst = '0;
      hdr_prio = '0;
      hdr_pgn = '0;
      stored_bytes = '0;
      half_valid = 1'b0;
      half_nib = '0;
      bad_type = 1'b0;
      return res;
   endfunction

   function automatic bit parse_char(input logic [7:0] ch, output result_type res);
      logic [4:0] hx;
      bit fired;
      hx = hex_digit(ch);
      res = NO_RESULT;
      fired = 1'b0;
      case (line_phase)
         PH_START: begin
            if (ch == CHAR_A) begin
               line_phase = PH_STAMP;
            end else if (ch == CHAR_NUL) begin
               res = close_line(STATUS_BAD_TYPE);
               fired = 1'b1;
            end else begin
               bad_type = 1'b1;
               line_phase = PH_WAIT;
            end
         end
         PH_STAMP: begin
            if (ch == CHAR_NUL) begin
               res = close_line(STATUS_EARLY_END);
               fired = 1'b1;
            end else if (ch == CHAR_SPACE) begin
               line_phase = PH_SKIP_A;
            end
         end
         PH_SKIP_A, PH_HDR: begin
            if (ch == CHAR_NUL) begin
               res = close_line(STATUS_EARLY_END);
               fired = 1'b1;
            end else if (!(line_phase == PH_SKIP_A && ch == CHAR_SPACE)) begin
               if (line_phase == PH_SKIP_A) begin
                  line_phase = PH_HDR;
                  digit_cnt = '0;
               end
               if (digit_cnt < 3'd2) hdr_src = {hdr_src[3:0], hx[3:0]};
               else if (digit_cnt < 3'd4) hdr_dst = {hdr_dst[3:0], hx[3:0]};
               else hdr_prio = hx[3:0];
               if (digit_cnt == 3'd4) begin
                  digit_cnt = '0;
                  line_phase = PH_SKIP_B;
               end else begin
                  digit_cnt = digit_cnt + 3'd1;
               end
            end
         end
         PH_SKIP_B, PH_PGN: begin
            if (ch == CHAR_NUL) begin
               res = close_line(STATUS_EARLY_END);
               fired = 1'b1;
            end else if (!(line_phase == PH_SKIP_B && ch == CHAR_SPACE)) begin
               if (line_phase == PH_SKIP_B) begin
                  line_phase = PH_PGN;
                  digit_cnt = '0;
               end
               hdr_pgn = {hdr_pgn[15:0], hx[3:0]};
               if (digit_cnt == 3'd4) begin
                  digit_cnt = '0;
                  line_phase = PH_DATA;
                  half_valid = 1'b0;
               end else begin
                  digit_cnt = digit_cnt + 3'd1;
               end
            end
         end
         PH_DATA: begin
            if (ch == CHAR_NUL) begin
               res = close_line(STATUS_OK);
               fired = 1'b1;
            end else if (ch == CHAR_CR || ch == CHAR_LF) begin
               res = close_line(STATUS_OK);
               fired = 1'b1;
               line_phase = PH_WAIT;
            end else if (!hx[4]) begin
               half_valid = 1'b0;
            end else if (!half_valid) begin
               half_valid = 1'b1;
               half_nib = hx[3:0];
            end else begin
               half_valid = 1'b0;
               // past the payload limit pairs are still consumed, just not stored
               if (stored_bytes < LINE_BYTES_MAX) begin
                  res.item_kind = KIND_DATA;
                  res.data_byte = {half_nib, hx[3:0]};
                  res.byte_index = stored_bytes;
                  stored_bytes = stored_bytes + 8'd1;
                  fired = 1'b1;
               end
            end
         end
         default: begin
            if (ch == CHAR_NUL) begin
               if (bad_type) begin
                  res = close_line(STATUS_BAD_TYPE);
                  fired = 1'b1;
               end else begin
                  void'(close_line(STATUS_OK));
               end
            end
         end
      endcase
      return fired;
   endfunction

   function automatic result_type fail_summary(input logic [1:0] st);
      result_type res;
      res = '0;
      res.item_kind = KIND_SUMMARY;
      res.status = st;
      return res;
   endfunction

   function automatic result_type data_result(input logic [7:0] b, input logic [7:0] idx);
      result_type res;
      res = '0;
      res.item_kind = KIND_DATA;
      res.data_byte = b;
      res.byte_index = idx;
      return res;
   endfunction

   function automatic logic [7:0] hex_char();
      int idx;
      idx = $urandom_range(0, 21);
      if (idx < 10) return 8'("0" + idx);
      if (idx < 16) return 8'("A" + idx - 10);
      return 8'("a" + idx - 16);
   endfunction

   function automatic logic [7:0] stamp_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CHAR_SPACE);
      return c;
   endfunction

   // mostly hex; now and then any non-NUL character, which counts as digit 0 unless it is hex
   function automatic logic [7:0] field_char();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
      return hex_char();
   endfunction

   function automatic logic [7:0] data_noise();
      logic [7:0] c;
      logic [4:0] hx;
      do begin
         c = 8'($urandom_range(1, 255));
         hx = hex_digit(c);
      end while (hx[4] || c == CHAR_CR || c == CHAR_LF);
      return c;
   endfunction

   task automatic send_char(input logic [7:0] ch, input bit typed, input result_type typed_res);
      int gap;
      bit fired;
      result_type res;
      gap = req_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (line_phase != PH_WAIT) live_chars++;
      fired = parse_char(ch, res);
      if (typed) parsed_items.push_back(typed_res);
      else if (fired) parsed_items.push_back(res);
   endtask

   task automatic random_line(input bit long_data);
      logic [7:0] text[$];
      logic [7:0] c;
      int pick, nbytes, keep, ending;
      pick = long_data ? 0 : $urandom_range(0, 99);
      if (pick >= 93) begin
         // bare NUL, or a run of noise
         if (pick >= 97)
            repeat ($urandom_range(1, 20)) text.push_back(8'($urandom_range(1, 255)));
      end else if (pick >= 85) begin
         do c = 8'($urandom_range(1, 255)); while (c == CHAR_A);
         text.push_back(c);
         repeat ($urandom_range(0, 8)) text.push_back(8'($urandom_range(1, 255)));
      end else begin
         text.push_back(CHAR_A);
         repeat ($urandom_range(0, 6)) text.push_back(stamp_char());
         repeat ($urandom_range(1, 3)) text.push_back(CHAR_SPACE);
         repeat (5) text.push_back(field_char());
         repeat ($urandom_range(0, 2)) text.push_back(CHAR_SPACE);
         repeat (5) text.push_back(field_char());
         repeat ($urandom_range(0, 2)) text.push_back(CHAR_SPACE);
         nbytes = long_data ? $urandom_range(LINE_BYTES_MAX + 1, LINE_BYTES_MAX + 12)
                            : $urandom_range(0, 12);
         repeat (nbytes) begin
            if ($urandom_range(0, 19) == 0) begin
               if ($urandom_range(0, 1) == 1) text.push_back(hex_char());
               text.push_back(data_noise());
            end
            text.push_back(hex_char());
            text.push_back(hex_char());
         end
         if ($urandom_range(0, 9) == 0) text.push_back(hex_char());
         if (pick >= 75) begin
            keep = $urandom_range(1, text.size());
            while (text.size() > keep) void'(text.pop_back());
         end else begin
            ending = $urandom_range(0, 2);
            if (ending != 0) begin
               text.push_back(ending == 1 ? CHAR_CR : CHAR_LF);
               repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(1, 255)));
            end
         end
      end
      text.push_back(CHAR_NUL);
      req_burst = ($urandom_range(0, 4) == 0);
      foreach (text[i]) send_char(text[i], 1'b0, NO_RESULT);
   endtask

   function automatic void check_field(input string name, input logic [19:0] want,
                                       input logic [19:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (parsed_items.size() == 0) begin
            $display("%0t: result expected none actual kind %0h byte %0h status %0h",
                     $time, rsp_item_kind, rsp_data_byte, rsp_status);
            mismatches++;
         end else begin
            want = parsed_items.pop_front();
            check_field("item_kind", 20'(want.item_kind), 20'(rsp_item_kind));
            check_field("data_byte", 20'(want.data_byte), 20'(rsp_data_byte));
            check_field("byte_index", 20'(want.byte_index), 20'(rsp_byte_index));
            check_field("source_addr", 20'(want.source_addr), 20'(rsp_source_addr));
            check_field("dest_addr", 20'(want.dest_addr), 20'(rsp_dest_addr));
            check_field("prio", 20'(want.prio), 20'(rsp_prio));
            check_field("pgn_value", want.pgn_value, rsp_pgn_value);
            check_field("payload_len", 20'(want.payload_len), 20'(rsp_payload_len));
            check_field("status", 20'(want.status), 20'(rsp_status));
         end
      end
   end

   // result side: stall before each transfer, sometimes in long no-stall stretches
   initial begin : rsp_drive
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin : stimulus
      stim_row_type directed [28];
      int line_no;
      directed = '{
         '{CHAR_NUL,   1'b1, fail_summary(STATUS_BAD_TYPE)},
         '{"X",        1'b0, NO_RESULT},
         '{CHAR_NUL,   1'b1, fail_summary(STATUS_BAD_TYPE)},
         '{CHAR_A,     1'b0, NO_RESULT},
         '{CHAR_NUL,   1'b1, fail_summary(STATUS_EARLY_END)},
         '{CHAR_A,     1'b0, NO_RESULT},
         '{"9",        1'b0, NO_RESULT},
         '{CHAR_SPACE, 1'b0, NO_RESULT},
         '{CHAR_SPACE, 1'b0, NO_RESULT},
         '{"0",        1'b0, NO_RESULT},
         '{"a",        1'b0, NO_RESULT},
         '{"f",        1'b0, NO_RESULT},
         '{"3",        1'b0, NO_RESULT},
         '{8'hFF,      1'b0, NO_RESULT},
         '{CHAR_SPACE, 1'b0, NO_RESULT},
         '{"1",        1'b0, NO_RESULT},
         '{"A",        1'b0, NO_RESULT},
         '{"b",        1'b0, NO_RESULT},
         '{"C",        1'b0, NO_RESULT},
         '{"d",        1'b0, NO_RESULT},
         '{"f",        1'b0, NO_RESULT},
         '{"F",        1'b1, data_result(8'hFF, 8'd0)},
         '{"0",        1'b0, NO_RESULT},
         '{"g",        1'b0, NO_RESULT},
         '{"0",        1'b0, NO_RESULT},
         '{CHAR_CR,    1'b0, NO_RESULT},
         '{"z",        1'b0, NO_RESULT},
         '{CHAR_NUL,   1'b0, NO_RESULT}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_char(directed[i].ch, directed[i].typed, directed[i].want);
      live_chars = 0;
      line_no = 0;
      while (live_chars < ITEM_TARGET) begin
         random_line(line_no == 5 || $urandom_range(0, 49) == 0);
         line_no++;
      end
      req_valid <= 1'b0;
      while (parsed_items.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
